// ----- src/aep_pkg.sv -----
// Shared types, constants and codes for the alignment error profile block.
package aep_pkg;

  localparam int MAX_POSITIONS_DEF = 16384;
  localparam int COUNT_W = 32;
  localparam int POS_W = 15;
  localparam int HIGH_W = 14;
  localparam int CHAR_W = 8;
  localparam int BIN_W = 14;

  localparam logic [CHAR_W-1:0] GAP_CHAR = 8'd45;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    KIND_IDENTITY,
    KIND_MISMATCH,
    KIND_INSERTION,
    KIND_DELETION
  } col_kind_t;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] query_char;
    logic [CHAR_W-1:0] genome_char;
    logic              exon_start;
    logic              forward;
    logic [POS_W-1:0]  query_from;
    logic [POS_W-1:0]  query_length;
    logic [BIN_W-1:0]  bin_index;
  } req_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] total_count;
    logic [COUNT_W-1:0] identity_count;
    logic [COUNT_W-1:0] mismatch_count;
    logic [COUNT_W-1:0] insertion_count;
    logic [COUNT_W-1:0] deletion_count;
    logic [HIGH_W-1:0]  highest_position;
    logic               out_of_range;
  } rsp_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] identity;
    logic [COUNT_W-1:0] mismatch;
    logic [COUNT_W-1:0] insertion;
    logic [COUNT_W-1:0] deletion;
  } counts_t;

  typedef struct packed {
    logic              read;
    logic              count;
    col_kind_t         kind;
    logic              bin_ok;
    logic [HIGH_W-1:0] highest;
    logic              out_of_range;
  } col_ctl_t;

endpackage

// ----- src/alignment_error_profile.sv -----
// Top level of the alignment error profile: clearing sweep, handshakes and submodules.
//
// Request channel (req_valid, req_stall, req): each item is either one alignment
// column to accumulate or a read of one position bin. Column items produce no
// result; a read item produces exactly one result on the response channel
// (rsp_valid, rsp_stall, rsp) with the five counters of the bin, the highest
// position counted and the sticky out-of-range flag.
// Items are taken one per cycle while req_stall is low. Each item reads its counter word from
// the memory at acceptance, and a column in range writes it back in the next cycle; a column that
// hits the word being written in that cycle is served by a forwarding register.
// A read result passes through the update stage and then the output register.
// While a result waits in the output register under rsp_stall, a following read
// item is held in the update stage and req_stall rises until the result leaves.
// After reset the counter memory is swept to zero, one word per cycle; req_stall is high
// until the last word has been written. Position, highest position and the out-of-range flag
// are cleared by reset at once, and the direction is set to forward.
module alignment_error_profile #(
  parameter int MAX_POSITIONS = aep_pkg::MAX_POSITIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  aep_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output aep_pkg::rsp_item_t  rsp
);
  import aep_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_POSITIONS - 1);

  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  logic              accept;
  logic              blocked;
  col_ctl_t          ctl;
  logic [ADDR_W-1:0] col_addr;
  counts_t           rd_data;
  logic              upd_wr_en;
  logic [ADDR_W-1:0] upd_wr_addr;
  counts_t           upd_wr_data;

  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  counts_t           mem_wr_data;

  assign req_stall = clearing || blocked;
  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_wr_en = 1'b1;
      mem_wr_addr = clear_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en = upd_wr_en;
      mem_wr_addr = upd_wr_addr;
      mem_wr_data = upd_wr_data;
    end
  end

  aep_track #(.MAX_POSITIONS(MAX_POSITIONS)) u_track (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (req),
    .ctl    (ctl),
    .addr   (col_addr)
  );

  aep_store #(.MAX_POSITIONS(MAX_POSITIONS)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (col_addr),
    .rd_data (rd_data)
  );

  aep_update #(.MAX_POSITIONS(MAX_POSITIONS)) u_update (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ctl       (ctl),
    .addr      (col_addr),
    .rd_data   (rd_data),
    .blocked   (blocked),
    .wr_en     (upd_wr_en),
    .wr_addr   (upd_wr_addr),
    .wr_data   (upd_wr_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_sweep_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clear_addr) == LAST_ADDR)
    else $error("Clearing sweep ended before the last word.");

  a_no_update_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !upd_wr_en)
    else $error("Counter update collided with the clearing sweep.");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !accept)
    else $error("Item accepted during the clearing sweep.");

endmodule

// ----- src/aep_store.sv -----
// Counter memory: one word of five counters per query position, one write and one read port.
module aep_store #(
  parameter int MAX_POSITIONS = aep_pkg::MAX_POSITIONS_DEF,
  localparam int ADDR_W = $clog2(MAX_POSITIONS)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  aep_pkg::counts_t     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output aep_pkg::counts_t     rd_data
);
  import aep_pkg::*;

  counts_t mem [MAX_POSITIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/aep_track.sv -----
// Query position tracking, column classification and the highest-position and range flags.
module aep_track #(
  parameter int MAX_POSITIONS = aep_pkg::MAX_POSITIONS_DEF,
  localparam int ADDR_W = $clog2(MAX_POSITIONS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  aep_pkg::req_item_t  item,
  output aep_pkg::col_ctl_t   ctl,
  output logic [ADDR_W-1:0]   addr
);
  import aep_pkg::*;

  logic [POS_W-1:0] current_position;
  logic             direction_forward;
  logic [POS_W-1:0] max_position;
  logic             range_error;

  logic             dir_eff;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_next;
  logic             in_range;
  logic             bin_ok;
  col_kind_t        kind;

  always_comb begin
    dir_eff = item.exon_start ? item.forward : direction_forward;
    pos_eff = current_position;
    if (item.exon_start) begin
      if (item.forward) begin
        pos_eff = item.query_from - POS_W'(1);
      end else begin
        pos_eff = item.query_length - item.query_from + POS_W'(1);
      end
    end
    pos_next = pos_eff;
    if (item.query_char != GAP_CHAR) begin
      pos_next = dir_eff ? pos_eff + POS_W'(1) : pos_eff - POS_W'(1);
    end
    in_range = 32'(pos_eff) < 32'(MAX_POSITIONS);
    bin_ok = 32'(item.bin_index) < 32'(MAX_POSITIONS);

    if (item.query_char == item.genome_char) begin
      kind = KIND_IDENTITY;
    end else if (item.query_char == GAP_CHAR) begin
      kind = KIND_DELETION;
    end else if (item.genome_char == GAP_CHAR) begin
      kind = KIND_INSERTION;
    end else begin
      kind = KIND_MISMATCH;
    end

    ctl.read = item.operation == OP_READ;
    ctl.count = (item.operation == OP_ACCUMULATE) && in_range;
    ctl.kind = kind;
    ctl.bin_ok = bin_ok;
    ctl.highest = max_position[HIGH_W-1:0];
    ctl.out_of_range = range_error;
    addr = (item.operation == OP_READ) ? ADDR_W'(item.bin_index) : ADDR_W'(pos_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
      direction_forward <= 1'b1;
      max_position <= '0;
      range_error <= 1'b0;
    end else if (accept && item.operation == OP_ACCUMULATE) begin
      current_position <= pos_next;
      direction_forward <= dir_eff;
      if (in_range) begin
        if (pos_eff > max_position) begin
          max_position <= pos_eff;
        end
      end else begin
        range_error <= 1'b1;
      end
    end
  end

endmodule

// ----- src/aep_update.sv -----
// Read-modify-write stage with forwarding, saturating counter update and result register.
module aep_update #(
  parameter int MAX_POSITIONS = aep_pkg::MAX_POSITIONS_DEF,
  localparam int ADDR_W = $clog2(MAX_POSITIONS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  aep_pkg::col_ctl_t   ctl,
  input  logic [ADDR_W-1:0]   addr,
  input  aep_pkg::counts_t    rd_data,
  output logic                blocked,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output aep_pkg::counts_t    wr_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output aep_pkg::rsp_item_t  rsp
);
  import aep_pkg::*;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

  logic              s1_valid;
  col_ctl_t          s1_ctl;
  logic [ADDR_W-1:0] s1_addr;
  logic              fwd_hit;
  counts_t           fwd_data;

  counts_t cur;
  counts_t upd;
  logic    s1_go;

  always_comb begin
    cur = fwd_hit ? fwd_data : rd_data;
    upd = cur;
    upd.total = sat_inc(cur.total);
    unique case (s1_ctl.kind)
      KIND_IDENTITY:  upd.identity = sat_inc(cur.identity);
      KIND_MISMATCH:  upd.mismatch = sat_inc(cur.mismatch);
      KIND_INSERTION: upd.insertion = sat_inc(cur.insertion);
      KIND_DELETION:  upd.deletion = sat_inc(cur.deletion);
    endcase
    s1_go = s1_valid && !(s1_ctl.read && rsp_valid && rsp_stall);
    blocked = s1_valid && !s1_go;
    wr_en = s1_valid && !s1_ctl.read && s1_ctl.count;
    wr_addr = s1_addr;
    wr_data = upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rsp_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit <= wr_en && (wr_addr == addr);
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && s1_ctl.read) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl <= ctl;
      s1_addr <= addr;
      fwd_data <= upd;
    end
    if (s1_go && s1_ctl.read) begin
      rsp.total_count <= s1_ctl.bin_ok ? cur.total : '0;
      rsp.identity_count <= s1_ctl.bin_ok ? cur.identity : '0;
      rsp.mismatch_count <= s1_ctl.bin_ok ? cur.mismatch : '0;
      rsp.insertion_count <= s1_ctl.bin_ok ? cur.insertion : '0;
      rsp.deletion_count <= s1_ctl.bin_ok ? cur.deletion : '0;
      rsp.highest_position <= s1_ctl.highest;
      rsp.out_of_range <= s1_ctl.out_of_range;
    end
  end

  a_write_only_accumulate: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !s1_ctl.read)
    else $error("Counter write issued for a read item.");

  a_read_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ctl.read && rsp_valid && rsp_stall) |=> (s1_valid && s1_ctl.read))
    else $error("Pending read item lost while the result register was stalled.");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("Accepted item did not reach the update stage.");

endmodule
